/* hdl/tts_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// tts_pkg
// Shared constants, node and command types, and sequencer states for the
// tournament tree sort unit.
// ============================================================================
package tts_pkg;

    localparam int LEAVES = 32;
    localparam int NODES  = 2 * LEAVES - 1;
    localparam int LEAF_W = $clog2(LEAVES);
    localparam int NODE_W = LEAF_W + 1;
    localparam int CNT_W  = $clog2(LEAVES + 1);
    localparam int IN_W   = 10;
    localparam int VAL_W  = 11;

    localparam logic [VAL_W-1:0] SENTINEL  = VAL_W'(1000);
    localparam logic [IN_W-1:0]  VALUE_MAX = IN_W'(999);

    // One tree node: the value that won there and the leaf it came from.
    typedef struct packed {
        logic [VAL_W-1:0]  val;
        logic [LEAF_W-1:0] leaf;
    } t_node;

    // Commands from the sequencer to the node memory.
    typedef struct packed {
        logic [NODE_W-1:0] rd_a;
        logic [NODE_W-1:0] rd_b;
        logic              we;
        logic [NODE_W-1:0] wr_addr;
        t_node             wr_data;
        logic              clr_one;
        logic [NODE_W-1:0] clr_addr;
        logic              clr_all;
    } t_mem_cmd;

    typedef enum logic [1:0] {
        S_LOAD,
        S_PLAY_RD,
        S_PLAY_WR,
        S_EMIT
    } t_state;

endpackage

/* hdl/tts_node_mem.sv */
`timescale 1ns / 1ps
// ============================================================================
// tts_node_mem
// Heap-ordered node store with two registered read ports, one write port and
// per-node valid bits; an invalid node reads as the sentinel.
// ============================================================================
module tts_node_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tts_pkg::t_mem_cmd i_cmd,
    output tts_pkg::t_node    o_rd_a,
    output tts_pkg::t_node    o_rd_b
);
    import tts_pkg::*;

    t_node             r_mem [NODES];
    logic [NODES-1:0]  r_vld;
    t_node             r_rd_a_data;
    t_node             r_rd_b_data;
    logic              r_rd_a_vld;
    logic              r_rd_b_vld;
    logic [LEAF_W-1:0] r_rd_a_leaf;
    logic [LEAF_W-1:0] r_rd_b_leaf;
    logic [NODE_W-1:0] leaf_off_a;
    logic [NODE_W-1:0] leaf_off_b;

    assign leaf_off_a = i_cmd.rd_a - NODE_W'(LEAVES - 1);
    assign leaf_off_b = i_cmd.rd_b - NODE_W'(LEAVES - 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_rd_a_data <= r_mem[i_cmd.rd_a];
        r_rd_b_data <= r_mem[i_cmd.rd_b];
        r_rd_a_vld  <= r_vld[i_cmd.rd_a];
        r_rd_b_vld  <= r_vld[i_cmd.rd_b];
        r_rd_a_leaf <= leaf_off_a[LEAF_W-1:0];
        r_rd_b_leaf <= leaf_off_b[LEAF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            r_vld <= '0;
        end else begin
            if (i_cmd.clr_one) begin
                r_vld[i_cmd.clr_addr] <= 1'b0;
            end
            if (i_cmd.we) begin
                r_vld[i_cmd.wr_addr] <= 1'b1;
            end
        end
    end

    // A node that is not valid (never written in this run, or cleared) reads as the sentinel and its own leaf.
    assign o_rd_a = r_rd_a_vld ? r_rd_a_data : t_node'{val: SENTINEL, leaf: r_rd_a_leaf};
    assign o_rd_b = r_rd_b_vld ? r_rd_b_data : t_node'{val: SENTINEL, leaf: r_rd_b_leaf};

endmodule

/* hdl/tts_cmp_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// tts_cmp_unit
// The single match comparator: picks the smaller of two children, with ties
// going to the left child (the lower leaf index).
// ============================================================================
module tts_cmp_unit (
    input  tts_pkg::t_node i_left,
    input  tts_pkg::t_node i_right,
    output tts_pkg::t_node o_win
);
    import tts_pkg::*;

    assign o_win = (i_right.val < i_left.val) ? i_right : i_left;

endmodule

/* hdl/tournament_tree_sort_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// tournament_tree_sort_unit
// Ascending tournament-tree sorter built around one shared comparator.
// ============================================================================
// Values are loaded one beat per cycle into the leaves of a 32-leaf tree;
// inputs above 999 are clamped to 999, and beats beyond the 32nd are dropped
// and reported through the overflow flag on every result of that set. The
// beat flagged last is loaded too unless it is beyond the 32nd, and starts
// sorting, during which the input is stalled. The whole tree is first played
// bottom-up, each inner node in a read state (the registered read of both
// children from the node memory) and then a write state (the comparison and
// write-back). For each result, once the output register is free, the root
// winner is handed to it and its leaf retired; that leaf's path is then
// replayed through the same comparator, a read and a write state per level.
// Results come out in ascending order with duplicates kept, the final one
// marked end_of_run; the tree is then emptied at once and the block takes
// the next set. A set always yields as many results as values it loaded,
// at least one.
// ============================================================================
module tournament_tree_sort_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [tts_pkg::IN_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [tts_pkg::IN_W-1:0] o_sorted_value,
    output logic                     o_end_of_run,
    output logic                     o_overflow
);
    import tts_pkg::*;

    t_state            r_state, n_state;
    logic [LEAF_W-1:0] r_node, n_node;
    logic              r_replay, n_replay;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [CNT_W-1:0]  r_emit_cnt, n_emit_cnt;
    t_node             r_win, n_win;
    logic              r_out_valid, n_out_valid;
    logic [IN_W-1:0]   r_out_value, n_out_value;
    logic              r_out_end, n_out_end;
    logic              r_out_ovf, n_out_ovf;

    t_mem_cmd          mem_cmd;
    t_node             rd_left;
    t_node             rd_right;
    t_node             cmp_win;
    logic [IN_W-1:0]   sat_value;
    logic [CNT_W-1:0]  emit_inc;
    logic [NODE_W-1:0] leaf_addr;
    logic [NODE_W-1:0] win_addr;
    logic [NODE_W-1:0] leaf_parent_sum;
    logic [LEAF_W-1:0] node_dec;
    logic              in_beat;
    logic              out_free;

    tts_node_mem u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (mem_cmd),
        .o_rd_a (rd_left),
        .o_rd_b (rd_right)
    );

    tts_cmp_unit u_cmp (
        .i_left (rd_left),
        .i_right(rd_right),
        .o_win  (cmp_win)
    );

    assign o_stall        = (r_state != S_LOAD);
    assign in_beat        = i_valid && !o_stall;
    assign out_free       = !r_out_valid || !i_stall;
    assign sat_value      = (i_value > VALUE_MAX) ? VALUE_MAX : i_value;
    assign emit_inc       = r_emit_cnt + CNT_W'(1);
    assign leaf_addr      = NODE_W'(LEAVES - 1) + NODE_W'(r_count);
    assign win_addr       = NODE_W'(LEAVES - 1) + NODE_W'(r_win.leaf);
    // Parent of the winning leaf: (LEAVES - 2 + leaf) / 2.
    assign leaf_parent_sum = NODE_W'(LEAVES - 2) + NODE_W'(r_win.leaf);
    assign node_dec       = r_node - LEAF_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_node      <= '0;
            r_replay    <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_emit_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_replay    <= n_replay;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_emit_cnt  <= n_emit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win       <= n_win;
        r_out_value <= n_out_value;
        r_out_end   <= n_out_end;
        r_out_ovf   <= n_out_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_node      = r_node;
        n_replay    = r_replay;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_emit_cnt  = r_emit_cnt;
        n_win       = r_win;
        n_out_valid = r_out_valid && i_stall;
        n_out_value = r_out_value;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;

        // Children of the current inner node are always on the read ports.
        mem_cmd          = '0;
        mem_cmd.rd_a     = {r_node, 1'b1};
        mem_cmd.rd_b     = {r_node, 1'b1} + NODE_W'(1);
        mem_cmd.clr_addr = win_addr;

        case (r_state)
            S_LOAD: begin
                if (in_beat) begin
                    if (r_count < CNT_W'(LEAVES)) begin
                        mem_cmd.we      = 1'b1;
                        mem_cmd.wr_addr = leaf_addr;
                        mem_cmd.wr_data = '{val: VAL_W'(sat_value),
                                            leaf: r_count[LEAF_W-1:0]};
                        n_count         = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_node     = LEAF_W'(LEAVES - 2);
                        n_replay   = 1'b0;
                        n_emit_cnt = '0;
                        n_state    = S_PLAY_RD;
                    end
                end
            end
            S_PLAY_RD: begin
                n_state = S_PLAY_WR;
            end
            S_PLAY_WR: begin
                mem_cmd.we      = 1'b1;
                mem_cmd.wr_addr = {1'b0, r_node};
                mem_cmd.wr_data = cmp_win;
                if (r_node == '0) begin
                    n_win   = cmp_win;
                    n_state = S_EMIT;
                end else begin
                    n_node  = r_replay ? {1'b0, node_dec[LEAF_W-1:1]} : node_dec;
                    n_state = S_PLAY_RD;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_win.val[IN_W-1:0];
                    n_out_end   = (emit_inc == r_count);
                    n_out_ovf   = r_ovf;
                    if (emit_inc == r_count) begin
                        mem_cmd.clr_all = 1'b1;
                        n_count         = '0;
                        n_ovf           = 1'b0;
                        n_emit_cnt      = '0;
                        n_state         = S_LOAD;
                    end else begin
                        mem_cmd.clr_one = 1'b1;
                        n_emit_cnt      = emit_inc;
                        n_node          = leaf_parent_sum[NODE_W-1:1];
                        n_replay        = 1'b1;
                        n_state         = S_PLAY_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_end_of_run   = r_out_end;
    assign o_overflow     = r_out_ovf;

`ifndef ASSERT_OFF
    // A winner at the root is always a loaded value, never an empty leaf.
    a_win_not_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_win.val < SENTINEL))
        else $error("root winner is the sentinel");

    // No more results are produced than values were loaded.
    a_emit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_emit_cnt < r_count))
        else $error("result count exceeds loaded count");

    // The last beat always starts a full bottom-up play from the deepest node.
    a_last_starts_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_last) |=>
            (r_state == S_PLAY_RD && !r_replay && r_node == LEAF_W'(LEAVES - 2)))
        else $error("last beat did not start a full play");

    // The fill count never passes the number of leaves.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LEAVES))
        else $error("fill count beyond leaf count");
`endif

endmodule
